// ===== rtl/tsfc_pkg.sv =====
// Shared types, widths and constants of the touch sample filter and calibrator.
package tsfc_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int PRESS_W    = 12;
  localparam int PIX_W      = 9;
  localparam int COEF_W     = 32;
  localparam int LIMIT_W    = 8;
  localparam int FRAC_BITS  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ACC_W      = COEF_W + SAMPLE_W + 2;
  localparam int FIG_W      = SAMPLE_W + 3 + PRESS_W;
  localparam int STEPS      = SAMPLE_W;
  localparam int CNT_W      = $clog2(STEPS);

  localparam logic signed [COEF_W-1:0] COEF_XX_RST = 32'sd2169096;
  localparam logic signed [COEF_W-1:0] COEF_XY_RST = 32'sd701;
  localparam logic signed [COEF_W-1:0] COEF_XO_RST = -32'sd419413287;
  localparam logic signed [COEF_W-1:0] COEF_YX_RST = -32'sd10096;
  localparam logic signed [COEF_W-1:0] COEF_YY_RST = 32'sd1386069;
  localparam logic signed [COEF_W-1:0] COEF_YO_RST = -32'sd592555834;
  localparam logic [LIMIT_W-1:0]       PLIMIT_RST  = 8'd4;

  localparam logic PT_PRESS   = 1'b1;
  localparam logic PT_RELEASE = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_XX        = 3'd0,
    CFG_COEF_XY        = 3'd1,
    CFG_COEF_XO        = 3'd2,
    CFG_COEF_YX        = 3'd3,
    CFG_COEF_YY        = 3'd4,
    CFG_COEF_YO        = 3'd5,
    CFG_PRESSURE_LIMIT = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic swap;
    logic step;
  } axis_ctl_t;

endpackage

// ===== rtl/tsfc_if.sv =====
// Request channel interfaces: panel scans in, calibrated points out.
interface tsfc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           pen_down;
  logic [tsfc_pkg::PRESS_W-1:0]   pressure_one;
  logic [tsfc_pkg::PRESS_W-1:0]   pressure_two;
  logic [tsfc_pkg::SAMPLE_W-1:0]  x_sample_a;
  logic [tsfc_pkg::SAMPLE_W-1:0]  x_sample_b;
  logic [tsfc_pkg::SAMPLE_W-1:0]  x_sample_c;
  logic [tsfc_pkg::SAMPLE_W-1:0]  y_sample_a;
  logic [tsfc_pkg::SAMPLE_W-1:0]  y_sample_b;
  logic [tsfc_pkg::SAMPLE_W-1:0]  y_sample_c;

  modport source (
    output valid, pen_down, pressure_one, pressure_two,
    output x_sample_a, x_sample_b, x_sample_c, y_sample_a, y_sample_b, y_sample_c,
    input  ready
  );
  modport sink (
    input  valid, pen_down, pressure_one, pressure_two,
    input  x_sample_a, x_sample_b, x_sample_c, y_sample_a, y_sample_b, y_sample_c,
    output ready
  );
endinterface

interface tsfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tsfc_pkg::PIX_W-1:0]   screen_x;
  logic [tsfc_pkg::PIX_W-1:0]   screen_y;
  logic                         is_pressed;

  modport source (output valid, screen_x, screen_y, is_pressed, input ready);
  modport sink (input valid, screen_x, screen_y, is_pressed, output ready);
endinterface

// ===== rtl/tsfc_axis.sv =====
// Bit-serial affine map of one screen axis with truncation and saturation.
module tsfc_axis #(
  parameter int SIZE = 480
) (
  input  logic                                 clk,
  input  tsfc_pkg::axis_ctl_t                  ctl,
  input  logic signed [tsfc_pkg::COEF_W-1:0]   gx,
  input  logic signed [tsfc_pkg::COEF_W-1:0]   gy,
  input  logic signed [tsfc_pkg::COEF_W-1:0]   off,
  input  logic [tsfc_pkg::SAMPLE_W-1:0]        x,
  input  logic [tsfc_pkg::SAMPLE_W-1:0]        y,
  output logic [tsfc_pkg::PIX_W-1:0]           pix
);

  localparam int WHOLE_W = tsfc_pkg::ACC_W - tsfc_pkg::FRAC_BITS;
  localparam logic [WHOLE_W-1:0]         PIX_MAX = WHOLE_W'(SIZE - 1);
  localparam logic [tsfc_pkg::PIX_W-1:0] PIX_SAT = tsfc_pkg::PIX_W'(SIZE - 1);

  logic signed [tsfc_pkg::ACC_W-1:0] acc_r;
  logic signed [tsfc_pkg::ACC_W-1:0] addend_r;
  logic [tsfc_pkg::SAMPLE_W-1:0]     mul_r;
  logic [WHOLE_W-1:0]                whole;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r    <= tsfc_pkg::ACC_W'(off);
      addend_r <= tsfc_pkg::ACC_W'(gx);
      mul_r    <= x;
    end else if (ctl.step) begin
      if (mul_r[0]) begin
        acc_r <= acc_r + addend_r;
      end
      if (ctl.swap) begin
        addend_r <= tsfc_pkg::ACC_W'(gy);
        mul_r    <= y;
      end else begin
        addend_r <= addend_r <<< 1;
        mul_r    <= mul_r >> 1;
      end
    end
  end

  assign whole = acc_r[tsfc_pkg::ACC_W-1:tsfc_pkg::FRAC_BITS];

  always_comb begin
    if (acc_r[tsfc_pkg::ACC_W-1]) begin
      pix = '0;
    end else if (whole > PIX_MAX) begin
      pix = PIX_SAT;
    end else begin
      pix = whole[tsfc_pkg::PIX_W-1:0];
    end
  end

endmodule

// ===== rtl/touch_sample_filter_calibrate.sv =====
// Touch sample filter and calibrator: median, pressure check and affine map.
//
// The block takes one panel scan per request on in_scan and returns at most one
// point per scan on out_pt. A scan with the pen down is filtered by a median of
// three on each axis, checked against the pressure limit with a bit-serial
// divider and multiplier, and mapped to the screen by two bit-serial
// multiply-accumulate units, one for each axis. A scan with the pen up after a
// press returns one release at the last point; other pen-up scans return nothing.
// A pen-down scan goes from acceptance through the load state, the 12 divider
// steps and the 12 multiplier steps to the done state and the output register;
// the axis maps run alongside them. A pen-up scan goes from acceptance straight
// to the done state. The block holds one scan at a time and takes the next one
// in the cycle after the finished point enters the output register, so it takes
// no new scan before it is through with the last one. Configuration writes on
// cfg_we, cfg_index and cfg_data are registered; the user must make them only
// while the block is idle, as the block itself does not enforce it. Reset
// restores the default calibration, clears the pressed state and empties the
// output register. When the receiver stalls, the point waits in the output
// register and a finished scan waits in its last state until the register frees.
module touch_sample_filter_calibrate #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 272,
  parameter int SAMPLE_BITS   = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tsfc_in_if.sink                              in_scan,
  tsfc_out_if.source                           out_pt,
  input  logic                                 cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsfc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [tsfc_pkg::SAMPLE_W-1:0] SMP_MASK =
    (SAMPLE_BITS >= tsfc_pkg::SAMPLE_W) ? '1 : tsfc_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [tsfc_pkg::CNT_W-1:0] CNT_LAST = tsfc_pkg::CNT_W'(tsfc_pkg::STEPS - 1);

  function automatic logic [tsfc_pkg::SAMPLE_W-1:0] med3(
    input logic [tsfc_pkg::SAMPLE_W-1:0] a,
    input logic [tsfc_pkg::SAMPLE_W-1:0] b,
    input logic [tsfc_pkg::SAMPLE_W-1:0] c
  );
    logic [tsfc_pkg::SAMPLE_W-1:0] lo;
    logic [tsfc_pkg::SAMPLE_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      med3 = lo;
    end else if (c >= hi) begin
      med3 = hi;
    end else begin
      med3 = c;
    end
  endfunction

  tsfc_pkg::state_t state_r, state_nxt;
  logic [tsfc_pkg::CNT_W-1:0] cnt_r;
  logic                       cnt_last;

  logic signed [tsfc_pkg::COEF_W-1:0] coef_xx_r, coef_xy_r, coef_xo_r;
  logic signed [tsfc_pkg::COEF_W-1:0] coef_yx_r, coef_yy_r, coef_yo_r;
  logic [tsfc_pkg::LIMIT_W-1:0]       plim_r;

  logic                          was_pressed_r;
  logic [tsfc_pkg::PIX_W-1:0]    last_x_r, last_y_r;

  logic                          pen_r;
  logic [tsfc_pkg::PRESS_W-1:0]  z1_r;
  logic [tsfc_pkg::PRESS_W-1:0]  dvd_r;
  logic [tsfc_pkg::PRESS_W-1:0]  rem_r;
  logic [tsfc_pkg::PRESS_W-1:0]  quo_r;
  logic [tsfc_pkg::SAMPLE_W-1:0] x_r, y_r;
  logic [tsfc_pkg::FIG_W-1:0]    fig_r, fmc_r;
  logic [tsfc_pkg::PRESS_W-1:0]  fml_r;
  logic                          qz_r;

  logic                          out_valid_r;
  logic [tsfc_pkg::PIX_W-1:0]    out_x_r, out_y_r;
  logic                          out_p_r;

  logic                          in_ready;
  logic                          accept;
  logic                          div_step, mul_step, commit;
  tsfc_pkg::axis_ctl_t           axis_ctl;

  logic [tsfc_pkg::PRESS_W:0]    rem_s;
  logic                          div_ge;
  logic [tsfc_pkg::PRESS_W-1:0]  quo_nxt;
  logic [tsfc_pkg::FIG_W-1:0]    limit;
  logic                          touch_ok;
  logic                          emit_press, emit_release;
  logic [tsfc_pkg::PIX_W-1:0]    pix_x, pix_y;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsfc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = in_scan.pen_down ? tsfc_pkg::ST_LOAD : tsfc_pkg::ST_DONE;
        end
      end
      tsfc_pkg::ST_LOAD: state_nxt = tsfc_pkg::ST_DIV;
      tsfc_pkg::ST_DIV: begin
        if (cnt_last) begin
          state_nxt = tsfc_pkg::ST_MUL;
        end
      end
      tsfc_pkg::ST_MUL: begin
        if (cnt_last) begin
          state_nxt = tsfc_pkg::ST_DONE;
        end
      end
      tsfc_pkg::ST_DONE: begin
        if (commit) begin
          state_nxt = tsfc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsfc_pkg::ST_IDLE;
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    in_ready       = 1'b0;
    div_step       = 1'b0;
    mul_step       = 1'b0;
    commit         = 1'b0;
    axis_ctl       = '0;
    unique case (state_r)
      tsfc_pkg::ST_IDLE: in_ready = 1'b1;
      tsfc_pkg::ST_LOAD: axis_ctl.start = 1'b1;
      tsfc_pkg::ST_DIV: begin
        div_step      = 1'b1;
        axis_ctl.step = 1'b1;
        axis_ctl.swap = cnt_last;
      end
      tsfc_pkg::ST_MUL: begin
        mul_step      = 1'b1;
        axis_ctl.step = 1'b1;
      end
      tsfc_pkg::ST_DONE: commit = !out_valid_r || out_pt.ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept   = in_scan.valid && in_ready;
  assign cnt_last = (cnt_r == CNT_LAST);

  // Restoring divider, one quotient bit per cycle.
  assign rem_s   = {rem_r, dvd_r[tsfc_pkg::PRESS_W-1]};
  assign div_ge  = (rem_s >= {1'b0, z1_r});
  assign quo_nxt = {quo_r[tsfc_pkg::PRESS_W-2:0], div_ge};

  assign limit    = tsfc_pkg::FIG_W'(plim_r) << SAMPLE_BITS;
  assign touch_ok = (z1_r != '0) && (qz_r || (fig_r <= limit));

  assign emit_press   = commit && pen_r && touch_ok;
  assign emit_release = commit && !pen_r && was_pressed_r;

  tsfc_axis #(.SIZE(SCREEN_WIDTH)) u_axis_x (
    .clk (clk),
    .ctl (axis_ctl),
    .gx  (coef_xx_r),
    .gy  (coef_xy_r),
    .off (coef_xo_r),
    .x   (x_r),
    .y   (y_r),
    .pix (pix_x)
  );

  tsfc_axis #(.SIZE(SCREEN_HEIGHT)) u_axis_y (
    .clk (clk),
    .ctl (axis_ctl),
    .gx  (coef_yx_r),
    .gy  (coef_yy_r),
    .off (coef_yo_r),
    .x   (x_r),
    .y   (y_r),
    .pix (pix_y)
  );

  // Control state, configuration and pressed state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tsfc_pkg::ST_IDLE;
      cnt_r         <= '0;
      coef_xx_r     <= tsfc_pkg::COEF_XX_RST;
      coef_xy_r     <= tsfc_pkg::COEF_XY_RST;
      coef_xo_r     <= tsfc_pkg::COEF_XO_RST;
      coef_yx_r     <= tsfc_pkg::COEF_YX_RST;
      coef_yy_r     <= tsfc_pkg::COEF_YY_RST;
      coef_yo_r     <= tsfc_pkg::COEF_YO_RST;
      plim_r        <= tsfc_pkg::PLIMIT_RST;
      was_pressed_r <= 1'b0;
      last_x_r      <= '0;
      last_y_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_step || mul_step) begin
        cnt_r <= cnt_last ? '0 : cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          tsfc_pkg::CFG_COEF_XX:        coef_xx_r <= cfg_data;
          tsfc_pkg::CFG_COEF_XY:        coef_xy_r <= cfg_data;
          tsfc_pkg::CFG_COEF_XO:        coef_xo_r <= cfg_data;
          tsfc_pkg::CFG_COEF_YX:        coef_yx_r <= cfg_data;
          tsfc_pkg::CFG_COEF_YY:        coef_yy_r <= cfg_data;
          tsfc_pkg::CFG_COEF_YO:        coef_yo_r <= cfg_data;
          tsfc_pkg::CFG_PRESSURE_LIMIT: plim_r    <= cfg_data[tsfc_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (emit_press) begin
        was_pressed_r <= 1'b1;
        last_x_r      <= pix_x;
        last_y_r      <= pix_y;
      end else if (emit_release) begin
        was_pressed_r <= 1'b0;
      end
      if (emit_press || emit_release) begin
        out_valid_r <= 1'b1;
      end else if (out_pt.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      pen_r <= in_scan.pen_down;
      z1_r  <= in_scan.pressure_one;
      dvd_r <= in_scan.pressure_two;
      rem_r <= '0;
      x_r   <= med3(in_scan.x_sample_a & SMP_MASK, in_scan.x_sample_b & SMP_MASK,
                    in_scan.x_sample_c & SMP_MASK);
      y_r   <= med3(in_scan.y_sample_a & SMP_MASK, in_scan.y_sample_b & SMP_MASK,
                    in_scan.y_sample_c & SMP_MASK);
    end
    if (div_step) begin
      rem_r <= div_ge ? tsfc_pkg::PRESS_W'(rem_s - {1'b0, z1_r})
                      : rem_s[tsfc_pkg::PRESS_W-1:0];
      dvd_r <= dvd_r << 1;
      quo_r <= quo_nxt;
      if (cnt_last) begin
        qz_r  <= (quo_nxt == '0);
        fml_r <= quo_nxt - 1'b1;
        fmc_r <= (tsfc_pkg::FIG_W'(x_r) << 2) + tsfc_pkg::FIG_W'(x_r);
        fig_r <= '0;
      end
    end
    if (mul_step) begin
      if (fml_r[0]) begin
        fig_r <= fig_r + fmc_r;
      end
      fmc_r <= fmc_r << 1;
      fml_r <= fml_r >> 1;
    end
    if (emit_press) begin
      out_x_r <= pix_x;
      out_y_r <= pix_y;
      out_p_r <= tsfc_pkg::PT_PRESS;
    end else if (emit_release) begin
      out_x_r <= last_x_r;
      out_y_r <= last_y_r;
      out_p_r <= tsfc_pkg::PT_RELEASE;
    end
  end

  assign in_scan.ready     = in_ready;
  assign out_pt.valid      = out_valid_r;
  assign out_pt.screen_x   = out_x_r;
  assign out_pt.screen_y   = out_y_r;
  assign out_pt.is_pressed = out_p_r;

endmodule

// ===== rtl/tsfc_checker.sv =====
// Port-level checks of the touch sample filter and calibrator, bound to the top level.
module tsfc_checker #(
  parameter int SCREEN_WIDTH  = 480,
  parameter int SCREEN_HEIGHT = 272
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tsfc_pkg::PIX_W-1:0]  out_x,
  input logic [tsfc_pkg::PIX_W-1:0]  out_y,
  input logic                        out_p
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_p))
    else $error("Stalled point changed before it was taken.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output register not empty after reset.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Scan accepted while another scan is in work.");

  a_no_early_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("Point appeared in the cycle right after its scan.");

  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((SCREEN_WIDTH > 512) || (int'(out_x) < SCREEN_WIDTH)) &&
                  ((SCREEN_HEIGHT > 512) || (int'(out_y) < SCREEN_HEIGHT)))
    else $error("Point lies outside the screen.");

endmodule

bind touch_sample_filter_calibrate tsfc_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tsfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_scan.valid),
  .in_ready  (in_scan.ready),
  .out_valid (out_pt.valid),
  .out_ready (out_pt.ready),
  .out_x     (out_pt.screen_x),
  .out_y     (out_pt.screen_y),
  .out_p     (out_pt.is_pressed)
);
